// File: rtl/manchester_led_frame_serializer_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Manchester LED frame serializer
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef MANCHESTER_LED_FRAME_SERIALIZER_ASSERT_SVH
`define MANCHESTER_LED_FRAME_SERIALIZER_ASSERT_SVH

// same-cycle implication
`define MLFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MLFS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/mlfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mlfs_pkg
// Shared types and constants of the Manchester LED frame serializer.
// ---------------------------------------------------------------------------
package mlfs_pkg;

  localparam int COLOR_BITS = 13;
  localparam int IN_BITS    = 13;
  localparam int CMD_BITS   = 3;
  localparam int PAT_BITS   = 32;
  localparam int PIX_BITS   = 3 * COLOR_BITS;
  localparam int FRAME_W    = (PIX_BITS > PAT_BITS) ? PIX_BITS : PAT_BITS;
  localparam int LEN_W      = $clog2(FRAME_W + 1);

  localparam logic [PAT_BITS-1:0] SYNC_PATTERN  = 32'hFFFE2000;
  localparam logic [PAT_BITS-1:0] RESET_PATTERN = 32'hFFFE8000;
  localparam logic [PAT_BITS-1:0] HEAD_PATTERN  = 32'hFFFE4000;
  localparam logic [LEN_W-1:0]    SYNC_LEN      = LEN_W'(30);
  localparam logic [LEN_W-1:0]    CTRL_LEN      = LEN_W'(19);
  localparam logic [LEN_W-1:0]    PIX_LEN       = LEN_W'(PIX_BITS);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_SYNC   = 3'd0,
    CMD_RESET  = 3'd1,
    CMD_HEAD   = 3'd2,
    CMD_RAW    = 3'd3,
    CMD_SCALED = 3'd4
  } cmd_t;

  // frame as sent: bits left aligned, MSB goes out first
  typedef struct packed {
    logic                 valid;
    logic [LEN_W-1:0]     len;
    logic [FRAME_W-1:0]   bits;
  } frame_t;

endpackage
`default_nettype wire

// File: rtl/mlfs_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mlfs_in_if
// Frame command channel: valid/ready with command and three colour words.
// ---------------------------------------------------------------------------
interface mlfs_in_if;
  logic                              valid;
  logic                              ready;
  logic [mlfs_pkg::CMD_BITS-1:0]     command;
  logic [mlfs_pkg::IN_BITS-1:0]      red;
  logic [mlfs_pkg::IN_BITS-1:0]      green;
  logic [mlfs_pkg::IN_BITS-1:0]      blue;

  modport source (output valid, command, red, green, blue, input ready);
  modport sink   (input valid, command, red, green, blue, output ready);
endinterface
`default_nettype wire

// File: rtl/mlfs_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mlfs_out_if
// Bit cell channel: valid/ready with the two half-cell levels and last flag.
// ---------------------------------------------------------------------------
interface mlfs_out_if;
  logic valid;
  logic ready;
  logic first_half;
  logic second_half;
  logic last;

  modport source (output valid, first_half, second_half, last, input ready);
  modport sink   (input valid, first_half, second_half, last, output ready);
endinterface
`default_nettype wire

// File: rtl/mlfs_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mlfs_lane
// One colour lane: passes the raw word or maps 8 bits to 12 bits.
// ---------------------------------------------------------------------------
module mlfs_lane (
  input  wire logic                              scaled,
  input  wire logic [mlfs_pkg::IN_BITS-1:0]      raw,
  output logic      [mlfs_pkg::COLOR_BITS-1:0]   word
);

  logic [7:0]  x;
  logic [8:0]  v;
  logic [15:0] prod;
  logic [3:0]  q;
  logic [11:0] s;
  logic [15:0] wide;

  // round(x/17) = (x+8)/17; v*241/4096 = v/17 * 4097/4096, floor exact for v < 4096
  assign x    = raw[7:0];
  assign v    = {1'b0, x} + 9'd8;
  assign prod = {7'd0, v} * 16'd241;
  assign q    = prod[15:12];
  assign s    = {x, 4'b0000} + {8'd0, q};
  assign wide = scaled ? {4'd0, s} : {3'd0, raw};
  assign word = wide[mlfs_pkg::COLOR_BITS-1:0];

endmodule
`default_nettype wire

// File: rtl/mlfs_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mlfs_merge
// Builds the left-aligned frame from the command and the lane words.
// ---------------------------------------------------------------------------
module mlfs_merge (
  input  wire logic [mlfs_pkg::CMD_BITS-1:0]     command,
  input  wire logic [mlfs_pkg::COLOR_BITS-1:0]   red_word,
  input  wire logic [mlfs_pkg::COLOR_BITS-1:0]   green_word,
  input  wire logic [mlfs_pkg::COLOR_BITS-1:0]   blue_word,
  output mlfs_pkg::frame_t                       frame
);

  logic [mlfs_pkg::FRAME_W-1:0] pix_bits;

  assign pix_bits = mlfs_pkg::FRAME_W'({red_word, green_word, blue_word})
                    << (mlfs_pkg::FRAME_W - mlfs_pkg::PIX_BITS);

  always_comb begin
    frame = '0;
    unique case (mlfs_pkg::cmd_t'(command))
      mlfs_pkg::CMD_SYNC: begin
        frame.valid = 1'b1;
        frame.len   = mlfs_pkg::SYNC_LEN;
        frame.bits  = mlfs_pkg::FRAME_W'(mlfs_pkg::SYNC_PATTERN)
                      << (mlfs_pkg::FRAME_W - mlfs_pkg::PAT_BITS);
      end
      mlfs_pkg::CMD_RESET: begin
        frame.valid = 1'b1;
        frame.len   = mlfs_pkg::CTRL_LEN;
        frame.bits  = mlfs_pkg::FRAME_W'(mlfs_pkg::RESET_PATTERN)
                      << (mlfs_pkg::FRAME_W - mlfs_pkg::PAT_BITS);
      end
      mlfs_pkg::CMD_HEAD: begin
        frame.valid = 1'b1;
        frame.len   = mlfs_pkg::CTRL_LEN;
        frame.bits  = mlfs_pkg::FRAME_W'(mlfs_pkg::HEAD_PATTERN)
                      << (mlfs_pkg::FRAME_W - mlfs_pkg::PAT_BITS);
      end
      mlfs_pkg::CMD_RAW, mlfs_pkg::CMD_SCALED: begin
        frame.valid = 1'b1;
        frame.len   = mlfs_pkg::PIX_LEN;
        frame.bits  = pix_bits;
      end
      default: begin
        // unknown command: dropped, no cells
        frame = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/manchester_led_frame_serializer.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// manchester_led_frame_serializer
// Turns frame commands into Manchester bit cells for an LED driver link.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch takes one frame command word (command, red, green, blue). Three
//   colour lanes form the words in parallel and a merge stage builds the
//   frame, which loads into a shift register in the accepting cycle.
//   out_ch gives one bit cell per word, MSB first: first_half is the data
//   bit, second_half its inverse, last marks the frame's final cell.
//   Sync frames give 30 cells, reset and head 19, pixels 3*COLOR_BITS (39).
//   Unknown commands are taken and dropped.
//   The command loads the shift register when accepted, and its first cell
//   then moves on to the output register. Throughput: one cell per cycle
//   while out_ch is ready, set by the single shift register; the next
//   command is taken in the cycle the previous frame's last cell moves to
//   the output register, so frames run back to back.
//   Reset clears the shift count and the output valid; nothing is pending.
//   A receiver stall holds the output register and freezes the shifter,
//   and in_ch.ready stays low until the frame's final cell is moving.
// ---------------------------------------------------------------------------
module manchester_led_frame_serializer (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mlfs_in_if.sink    in_ch,
  mlfs_out_if.source out_ch
);

  logic [mlfs_pkg::COLOR_BITS-1:0] red_word, green_word, blue_word;
  logic                            scaled;
  mlfs_pkg::frame_t                frame;

  logic [mlfs_pkg::FRAME_W-1:0] shift_r, shift_nxt;
  logic [mlfs_pkg::LEN_W-1:0]   cnt_r, cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_bit_r, out_bit_nxt;
  logic                         out_last_r, out_last_nxt;
  logic                         busy, move, final_cell, accept, load;

  assign scaled = (mlfs_pkg::cmd_t'(in_ch.command) == mlfs_pkg::CMD_SCALED);

  mlfs_lane u_lane_red   (.scaled(scaled), .raw(in_ch.red),   .word(red_word));
  mlfs_lane u_lane_green (.scaled(scaled), .raw(in_ch.green), .word(green_word));
  mlfs_lane u_lane_blue  (.scaled(scaled), .raw(in_ch.blue),  .word(blue_word));

  mlfs_merge u_merge (
    .command    (in_ch.command),
    .red_word   (red_word),
    .green_word (green_word),
    .blue_word  (blue_word),
    .frame      (frame)
  );

  assign busy       = (cnt_r != '0);
  assign move       = busy && (!out_valid_r || out_ch.ready);
  assign final_cell = (cnt_r == mlfs_pkg::LEN_W'(1));
  assign in_ch.ready = !busy || (final_cell && move);
  assign accept     = in_ch.valid && in_ch.ready;
  assign load       = accept && frame.valid;

  always_comb begin
    shift_nxt     = shift_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_bit_nxt   = out_bit_r;
    out_last_nxt  = out_last_r;
    if (move) begin
      out_bit_nxt   = shift_r[mlfs_pkg::FRAME_W-1];
      out_last_nxt  = final_cell;
      out_valid_nxt = 1'b1;
      shift_nxt     = shift_r << 1;
      cnt_nxt       = cnt_r - mlfs_pkg::LEN_W'(1);
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    // a new frame only loads once the old one's final cell is moving out
    if (load) begin
      shift_nxt = frame.bits;
      cnt_nxt   = frame.len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    shift_r    <= shift_nxt;
    out_bit_r  <= out_bit_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.first_half  = out_bit_r;
  assign out_ch.second_half = !out_bit_r;
  assign out_ch.last        = out_last_r;

`include "manchester_led_frame_serializer_assert.svh"

  `MLFS_ASSERT_IMP(a_no_accept_mid_frame, cnt_r > mlfs_pkg::LEN_W'(1), !in_ch.ready, "command accepted mid frame")
  `MLFS_ASSERT_NXT(a_last_on_final, move && final_cell && !load, out_last_r && out_valid_r && !busy, "final cell not flagged")
  `MLFS_ASSERT_NXT(a_hold_on_stall, busy && !move, $stable(shift_r) && $stable(cnt_r), "shifter moved while stalled")
  `MLFS_ASSERT_NXT(a_load_count, load, cnt_r == $past(frame.len), "frame length not loaded")

endmodule
`default_nettype wire

// File: tb/mlfs_frame_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mlfs_frame_checker
// Watches both channels of the Manchester frame serializer, builds the bit
// cells each accepted frame command should produce and compares every
// outgoing cell, in order, with the oldest one still owed.
// ---------------------------------------------------------------------------
module mlfs_frame_checker
  import mlfs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  mlfs_in_if   in_mon,
  mlfs_out_if  out_mon,
  output int   fail_cnt,
  output int   pending
);

  typedef struct packed {
    logic first_half;
    logic second_half;
    logic last;
  } cell_t;

  cell_t expected_cells[$];

  // 8-bit level to 12 bits, rounded: 16x + round(x/17)
  function automatic logic [11:0] scale_to_12(logic [7:0] x);
    int xi;
    xi = int'(x);
    return 12'(16 * xi + (xi + 8) / 17);
  endfunction

  task automatic queue_frame_cells(logic [CMD_BITS-1:0] cmd, logic [IN_BITS-1:0] r,
                                   logic [IN_BITS-1:0] g, logic [IN_BITS-1:0] b);
    logic [FRAME_W-1:0]    frame;
    logic [COLOR_BITS-1:0] rc, gc, bc;
    int                    len;
    cell_t                 c;
    len = 0;
    frame = '0;
    case (cmd)
      CMD_SYNC: begin
        frame = FRAME_W'(SYNC_PATTERN) << (FRAME_W - PAT_BITS);
        len   = int'(SYNC_LEN);
      end
      CMD_RESET: begin
        frame = FRAME_W'(RESET_PATTERN) << (FRAME_W - PAT_BITS);
        len   = int'(CTRL_LEN);
      end
      CMD_HEAD: begin
        frame = FRAME_W'(HEAD_PATTERN) << (FRAME_W - PAT_BITS);
        len   = int'(CTRL_LEN);
      end
      CMD_RAW, CMD_SCALED: begin
        if (cmd == CMD_RAW) begin
          rc = COLOR_BITS'(r);
          gc = COLOR_BITS'(g);
          bc = COLOR_BITS'(b);
        end else begin
          rc = COLOR_BITS'(scale_to_12(r[7:0]));
          gc = COLOR_BITS'(scale_to_12(g[7:0]));
          bc = COLOR_BITS'(scale_to_12(b[7:0]));
        end
        frame = FRAME_W'({rc, gc, bc}) << (FRAME_W - PIX_BITS);
        len   = int'(PIX_LEN);
      end
      default: len = 0; // unknown command is dropped
    endcase
    for (int i = 0; i < len; i++) begin
      c.first_half  = frame[FRAME_W-1-i];
      c.second_half = ~frame[FRAME_W-1-i];
      c.last        = (i == len - 1);
      expected_cells.push_back(c);
    end
  endtask

  task automatic flag_cell(string why, cell_t exp, cell_t got);
    fail_cnt <= fail_cnt + 1;
    if (fail_cnt < 10)
      $display("frame checker: %s at %0t: exp f/s/l=%b%b%b got %b%b%b", why, $realtime,
               exp.first_half, exp.second_half, exp.last,
               got.first_half, got.second_half, got.last);
  endtask

  always @(posedge clk) begin
    cell_t got, exp;
    if (!rst_n) begin
      fail_cnt <= 0;
      expected_cells.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        queue_frame_cells(in_mon.command, in_mon.red, in_mon.green, in_mon.blue);
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.first_half, out_mon.second_half, out_mon.last};
        if (expected_cells.size() == 0) begin
          flag_cell("unexpected word", 'x, got);
        end else begin
          exp = expected_cells.pop_front();
          if (got !== exp) flag_cell("cell mismatch", exp, got);
        end
      end
    end
    pending <= expected_cells.size();
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Drives frame commands into the Manchester frame serializer with random
// sender gaps and receiver stalls, one long receiver hold-off, and a quiet
// tail; the frame checker beside the block reports the failure count.
// ---------------------------------------------------------------------------
module tb_top;
  import mlfs_pkg::*;

  localparam logic [CMD_BITS-1:0] CMD_BAD_LO = 3'd5;
  localparam logic [CMD_BITS-1:0] CMD_BAD_MID = 3'd6;
  localparam logic [CMD_BITS-1:0] CMD_BAD_HI = 3'd7;
  localparam int RAND_FRAMES = 255;
  localparam int QUIET_FROM = 220;
  localparam logic [IN_BITS-1:0] ALL_ONES = '1;

  logic clk = 1'b0;
  logic rst_n;
  logic calm;
  int   item_no;
  int   fail_cnt;
  int   pending;

  mlfs_in_if  in_ch ();
  mlfs_out_if out_ch ();

  manchester_led_frame_serializer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mlfs_frame_checker chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_mon   (in_ch),
    .out_mon  (out_ch),
    .fail_cnt (fail_cnt),
    .pending  (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // offer one command and hold it until taken; maybe idle afterwards
  task automatic send_cmd(logic [CMD_BITS-1:0] cmd, logic [IN_BITS-1:0] r,
                          logic [IN_BITS-1:0] g, logic [IN_BITS-1:0] b);
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.red     <= r;
    in_ch.green   <= g;
    in_ch.blue    <= b;
    do @(posedge clk); while (!in_ch.ready);
    item_no++;
    // every third stretch of 40 words goes without gaps
    if (!calm && (item_no / 40) % 3 != 2 && $urandom_range(0, 2) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  initial begin
    int framed;
    logic [CMD_BITS-1:0] cmd;
    calm          = 1'b0;
    item_no       = 0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.command <= CMD_SYNC;
    in_ch.red     <= '0;
    in_ch.green   <= '0;
    in_ch.blue    <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: each frame type, field extremes, scaling corners, dropped commands
    send_cmd(CMD_SYNC, '0, '0, '0);
    send_cmd(CMD_RESET, '0, '0, '0);
    send_cmd(CMD_HEAD, '0, '0, '0);
    send_cmd(CMD_RAW, '0, '0, '0);
    send_cmd(CMD_RAW, ALL_ONES, ALL_ONES, ALL_ONES);
    send_cmd(CMD_RAW, 13'h1555, 13'h0AAA, 13'h1555);
    send_cmd(CMD_RAW, 13'h1000, 13'h0001, 13'h0FFF);
    send_cmd(CMD_SCALED, 13'd0, 13'd255, 13'd128);
    send_cmd(CMD_SCALED, 13'd8, 13'd9, 13'd254);        // rounding edge of x/17
    send_cmd(CMD_SCALED, 13'h1F00, 13'h1FAA, ALL_ONES); // upper bits ignored
    send_cmd(CMD_BAD_LO, ALL_ONES, ALL_ONES, ALL_ONES);
    send_cmd(CMD_BAD_MID, '0, '0, '0);
    send_cmd(CMD_BAD_HI, 13'h0AAA, 13'h1555, 13'h0AAA);
    send_cmd(CMD_SYNC, ALL_ONES, ALL_ONES, ALL_ONES);
    send_cmd(CMD_HEAD, ALL_ONES, '0, ALL_ONES);
    send_cmd(CMD_RESET, '0, ALL_ONES, '0);
    send_cmd(CMD_SCALED, 13'd17, 13'd170, 13'd1);

    // random: mostly real frames, a few dropped commands mixed in
    framed = 0;
    while (framed < RAND_FRAMES) begin
      if ($urandom_range(0, 9) == 0) begin
        cmd = CMD_BITS'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
      end else begin
        cmd = CMD_BITS'($urandom_range(CMD_SYNC, CMD_SCALED));
        framed++;
      end
      if (framed >= QUIET_FROM) calm = 1'b1;
      send_cmd(cmd, IN_BITS'($urandom_range(0, 8191)), IN_BITS'($urandom_range(0, 8191)),
               IN_BITS'($urandom_range(0, 8191)));
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // receiver: one long hold-off so the block backs up, then random stalls
  initial begin
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    out_ch.ready <= 1'b1;
    repeat (300) @(posedge clk);
    out_ch.ready <= 1'b0;
    repeat (400) @(posedge clk);
    out_ch.ready <= 1'b1;
    @(posedge clk);
    while (!calm) begin
      if ($urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(40, 120)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
    out_ch.ready <= 1'b1;
  end

  initial begin
    #20ms;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
